### rtl/sai_pkg.sv
// sai_pkg: shared types, constants and the micro-op encoding for the
// steering arrive integrator. No dependencies.
package sai_pkg;

  localparam int DefFracBits = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PLACE,
    ST_FMAG,
    ST_FSCX,
    ST_FSCY,
    ST_VADD,
    ST_LAUNCH,
    ST_DMAG,
    ST_DLIM,
    ST_VMAG,
    ST_VSCX,
    ST_VSCY,
    ST_PADD,
    ST_OUT
  } sai_state_t;

  typedef enum logic [1:0] {
    REG_MAX_FORCE     = 2'd0,
    REG_MAX_SPEED     = 2'd1,
    REG_ARRIVE_RADIUS = 2'd2
  } sai_reg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PLACE,
    OP_FMAG,
    OP_FSCX,
    OP_FSCY,
    OP_VADD,
    OP_DMAG,
    OP_DLIM,
    OP_VMAG,
    OP_VSCX,
    OP_VSCY,
    OP_PADD
  } sai_op_t;

  typedef struct packed {
    sai_op_t op;
    logic    start;
  } sai_cmd_t;

  typedef struct packed {
    logic done;
    logic place;
    logic arrive;
    logic f_over;
    logic d_in;
    logic v_over;
  } sai_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) sat32 = 32'sh7fffffff;
    else if (v < -34'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

endpackage

### rtl/sai_if.sv
// sai_if: valid/ready channel carrying a generic payload.
// Depends on nothing.
interface sai_if #(parameter int W = 32) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/steering_arrive_integrator.sv
// steering_arrive_integrator: top level joining controller and datapath.
// Depends on sai_pkg, sai_if, sai_ctrl and sai_dp.
// One item at a time, and the next transfer in waits until the result has been
// taken. A step runs the shared 32-step square root and 63-step divider
// (two or three roots and up to five divisions) between the accept, launch,
// add and output states; a place uses neither.
module steering_arrive_integrator #(
  parameter int FRAC_BITS = sai_pkg::DefFracBits
) (
  input  logic clk,
  input  logic rst_n,
  sai_if.sink   in_ch,
  sai_if.source out_ch,
  sai_if.sink   cfg_ch
);
  import sai_pkg::*;

  sai_cmd_t  cmd;
  sai_stat_t stat;
  logic      in_fire;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  sai_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_ready(out_ch.ready),
    .in_ready(in_ch.ready), .out_valid(out_ch.valid), .cmd(cmd), .stat(stat)
  );

  sai_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_data(in_ch.data[193:0]),
    .cfg_fire(cfg_ch.valid && cfg_ch.ready),
    .cfg_index(cfg_ch.data[32:31]), .cfg_data(cfg_ch.data[30:0]),
    .out_data(out_ch.data[127:0])
  );
endmodule

### rtl/sai_ctrl.sv
// sai_ctrl: sequencer for the step and place commands.
// Depends on sai_pkg.
module sai_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic               out_ready,
  output logic               in_ready,
  output logic               out_valid,
  output sai_pkg::sai_cmd_t  cmd,
  input  sai_pkg::sai_stat_t stat
);
  import sai_pkg::*;

  sai_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op = OP_NONE;
    cmd.start = 1'b0;
    in_ready = (state_r == ST_IDLE);
    out_valid = (state_r == ST_OUT);
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.op = OP_LOAD;
          state_nxt = ST_PLACE;
        end
      end
      ST_PLACE: begin
        if (stat.place) begin
          cmd.op = OP_PLACE;
          state_nxt = ST_OUT;
        end else begin
          cmd.op = OP_FMAG; cmd.start = 1'b1; state_nxt = ST_FMAG;
        end
      end
      ST_FMAG: begin
        cmd.op = OP_FMAG;
        if (stat.done) begin
          if (stat.f_over) begin
            cmd.op = OP_FSCX; cmd.start = 1'b1; state_nxt = ST_FSCX;
          end else state_nxt = ST_VADD;
        end
      end
      ST_FSCX: begin
        cmd.op = OP_FSCX;
        if (stat.done) begin
          cmd.op = OP_FSCY; cmd.start = 1'b1; state_nxt = ST_FSCY;
        end
      end
      ST_FSCY: begin
        cmd.op = OP_FSCY;
        if (stat.done) state_nxt = ST_VADD;
      end
      ST_VADD: begin
        cmd.op = OP_VADD;
        state_nxt = ST_LAUNCH;
      end
      ST_LAUNCH: begin
        cmd.start = 1'b1;
        if (stat.arrive) begin
          cmd.op = OP_DMAG; state_nxt = ST_DMAG;
        end else begin
          cmd.op = OP_VMAG; state_nxt = ST_VMAG;
        end
      end
      ST_DMAG: begin
        cmd.op = OP_DMAG;
        if (stat.done) begin
          if (stat.d_in) begin
            cmd.op = OP_DLIM; cmd.start = 1'b1; state_nxt = ST_DLIM;
          end else begin
            cmd.op = OP_VMAG; cmd.start = 1'b1; state_nxt = ST_VMAG;
          end
        end
      end
      ST_DLIM: begin
        cmd.op = OP_DLIM;
        if (stat.done) begin
          cmd.op = OP_VMAG; cmd.start = 1'b1; state_nxt = ST_VMAG;
        end
      end
      ST_VMAG: begin
        cmd.op = OP_VMAG;
        if (stat.done) begin
          if (stat.v_over) begin
            cmd.op = OP_VSCX; cmd.start = 1'b1; state_nxt = ST_VSCX;
          end else state_nxt = ST_PADD;
        end
      end
      ST_VSCX: begin
        cmd.op = OP_VSCX;
        if (stat.done) begin
          cmd.op = OP_VSCY; cmd.start = 1'b1; state_nxt = ST_VSCY;
        end
      end
      ST_VSCY: begin
        cmd.op = OP_VSCY;
        if (stat.done) state_nxt = ST_PADD;
      end
      ST_PADD: begin
        cmd.op = OP_PADD;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_out_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("out valid while idle");
  a_accept_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_PLACE) else $error("accept not followed");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

### rtl/sai_dp.sv
// sai_dp: agent state, configuration registers, a bit-serial square root
// and a restoring divider shared by all magnitude, scale and arrive-limit steps.
// Depends on sai_pkg.
module sai_dp #(
  parameter int FRAC_BITS = sai_pkg::DefFracBits
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sai_pkg::sai_cmd_t  cmd,
  output sai_pkg::sai_stat_t stat,
  input  logic [193:0]       in_data,
  input  logic               cfg_fire,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  output logic [127:0]       out_data
);
  import sai_pkg::*;

  localparam logic [31:0] VelReset = 32'(((64'd6 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [30:0] ForceReset = 31'(((64'd3 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [30:0] SpeedReset = 31'(((64'd35 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [30:0] RadiusReset = 31'(64'd5 << FRAC_BITS);

  logic [30:0] max_force_r, max_speed_r, radius_r, lim_r;
  logic signed [31:0] px_r, py_r, vx_r, vy_r, ax_r, ay_r;
  logic signed [31:0] tx_r, ty_r;
  logic place_r, arrive_r;

  // iterative unit state
  logic [63:0] rem_r, res_r, bit_r;
  logic [62:0] num_r;
  logic [62:0] quo_r;
  logic [31:0] den_r;
  logic [6:0]  cnt_r;
  logic        busy_r, sq_r;
  sai_op_t     run_op_r;
  logic signed [31:0] comp_sel;
  logic [31:0] abs_a, abs_b;
  logic [63:0] sumsq, prod;
  logic [31:0] div_rem_r;
  logic [32:0] trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_force_r <= ForceReset;
      max_speed_r <= SpeedReset;
      radius_r <= RadiusReset;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_MAX_FORCE: max_force_r <= cfg_data;
        REG_MAX_SPEED: max_speed_r <= cfg_data;
        REG_ARRIVE_RADIUS: radius_r <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [31:0] absv(input logic signed [31:0] v);
    absv = v[31] ? 32'(-v) : 32'(v);
  endfunction

  always_comb begin
    unique case (cmd.op)
      OP_FMAG: begin abs_a = absv(ax_r); abs_b = absv(ay_r); end
      OP_DMAG: begin abs_a = absv(tx_r); abs_b = absv(ty_r); end
      default: begin abs_a = absv(vx_r); abs_b = absv(vy_r); end
    endcase
    sumsq = 64'(abs_a) * 64'(abs_a) + 64'(abs_b) * 64'(abs_b);
    unique case (cmd.op)
      OP_FSCX: comp_sel = ax_r;
      OP_FSCY: comp_sel = ay_r;
      OP_VSCX: comp_sel = vx_r;
      default: comp_sel = vy_r;
    endcase
    unique case (cmd.op)
      OP_DLIM: prod = 64'(max_speed_r) * 64'(res_r[31:0]);
      OP_FSCX, OP_FSCY: prod = 64'(absv(comp_sel)) * 64'(max_force_r);
      default: prod = 64'(absv(comp_sel)) * 64'(lim_r);
    endcase
    trial = {div_rem_r, num_r[62]} - {1'b0, den_r};
  end

  logic [31:0] qv;
  assign qv = quo_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= '0; py_r <= '0; vx_r <= VelReset; vy_r <= '0;
      busy_r <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          place_r <= in_data[0];
          ax_r <= in_data[32:1]; ay_r <= in_data[64:33];
          tx_r <= in_data[0] ? in_data[161:130] : in_data[96:65];
          ty_r <= in_data[0] ? in_data[193:162] : in_data[128:97];
          arrive_r <= in_data[129];
          lim_r <= max_speed_r;
        end
        OP_PLACE: begin
          px_r <= tx_r; py_r <= ty_r;
          vx_r <= VelReset; vy_r <= '0;
        end
        OP_VADD: begin
          vx_r <= sat32(34'(vx_r) + 34'(ax_r));
          vy_r <= sat32(34'(vy_r) + 34'(ay_r));
          tx_r <= sat32(34'(tx_r) - 34'(px_r));
          ty_r <= sat32(34'(ty_r) - 34'(py_r));
        end
        OP_PADD: begin
          px_r <= sat32(34'(px_r) + 34'(vx_r));
          py_r <= sat32(34'(py_r) + 34'(vy_r));
        end
        default: ;
      endcase
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
        run_op_r <= cmd.op;
        if (cmd.op == OP_FMAG || cmd.op == OP_DMAG || cmd.op == OP_VMAG) begin
          sq_r <= 1'b1; rem_r <= sumsq; res_r <= '0; bit_r <= 64'd1 << 62;
        end else begin
          sq_r <= 1'b0;
          num_r <= prod[62:0];
          den_r <= (cmd.op == OP_DLIM) ? {1'b0, radius_r} : res_r[31:0];
          div_rem_r <= '0; quo_r <= '0;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (sq_r) begin
          if (rem_r >= res_r + bit_r) begin
            rem_r <= rem_r - (res_r + bit_r);
            res_r <= (res_r >> 1) + bit_r;
          end else res_r <= res_r >> 1;
          bit_r <= bit_r >> 2;
          if (cnt_r == 7'd31) begin
            busy_r <= 1'b0;
          end
        end else begin
          num_r <= {num_r[61:0], 1'b0};
          if (!trial[32]) begin
            div_rem_r <= trial[31:0]; quo_r <= {quo_r[61:0], 1'b1};
          end else begin
            div_rem_r <= {div_rem_r[30:0], num_r[62]}; quo_r <= {quo_r[61:0], 1'b0};
          end
          if (cnt_r == 7'd62) busy_r <= 1'b0;
        end
      end
      if (stat.done) begin
        unique case (run_op_r)
          OP_DLIM: lim_r <= (radius_r == '0) ? '0 : qv[30:0];
          OP_FSCX: ax_r <= ax_r[31] ? 32'(-qv) : qv;
          OP_FSCY: ay_r <= ay_r[31] ? 32'(-qv) : qv;
          OP_VSCX: vx_r <= vx_r[31] ? 32'(-qv) : qv;
          OP_VSCY: vy_r <= vy_r[31] ? 32'(-qv) : qv;
          default: ;
        endcase
      end
    end
  end

  // done is registered: it rises in the cycle after the last iteration
  logic fin_r;
  always_ff @(posedge clk) begin
    if (!rst_n) fin_r <= 1'b0;
    else fin_r <= busy_r && !cmd.start &&
                  ((sq_r && cnt_r == 7'd31) || (!sq_r && cnt_r == 7'd62));
  end

  always_comb begin
    stat.done = fin_r;
    stat.place = place_r;
    stat.arrive = arrive_r;
    stat.f_over = res_r[31:0] > {1'b0, max_force_r};
    stat.d_in = res_r[31:0] <= {1'b0, radius_r};
    stat.v_over = res_r[31:0] > {1'b0, lim_r};
  end

  assign out_data = {vy_r, vx_r, py_r, px_r};

  a_fin_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |=> !fin_r) else $error("done held");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> busy_r) else $error("unit not started");
  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |-> !busy_r) else $error("done while busy");
endmodule
